// ===== sv/hpc_pkg.sv =====
// hpc_pkg: shared types, constants and helper functions of the height profile classifier
// no dependencies; imported by height_profile_classifier, hpc_checker and tb_top

package hpc_pkg;

	// field widths
	localparam int CFG_W    = 12;
	localparam int CMP_W    = 16;
	localparam int HEIGHT_W = 11;
	localparam int TYPE_W   = 2;
	localparam int STAT_W   = 2;
	localparam int NUM_W    = 14;

	// profile evaluation constants
	localparam int ZERO_LEVEL  = 3640;
	localparam int MIN_PROFILE = 21;
	localparam int OUTER_SKIP  = 6;
	localparam int MID_HALF    = 5;
	localparam int MID_LEN     = 10;
	localparam int DIV_THIRD   = 3;
	localparam int DIV_TEN     = 10;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_OUTER_HIGH_LOW  = 3'd0,
		REG_OUTER_HIGH_HIGH = 3'd1,
		REG_HOLE_MID_LOW    = 3'd2,
		REG_HOLE_MID_HIGH   = 3'd3,
		REG_HIGH_MID_LOW    = 3'd4,
		REG_HIGH_MID_HIGH   = 3'd5,
		REG_FLAT_LOW        = 3'd6,
		REG_FLAT_HIGH       = 3'd7
	} reg_idx_t;

	// register reset values
	localparam logic [CFG_W-1:0] RST_OUTER_HIGH_LOW  = 12'd2345;
	localparam logic [CFG_W-1:0] RST_OUTER_HIGH_HIGH = 12'd2400;
	localparam logic [CFG_W-1:0] RST_HOLE_MID_LOW    = 12'd3000;
	localparam logic [CFG_W-1:0] RST_HOLE_MID_HIGH   = 12'd3400;
	localparam logic [CFG_W-1:0] RST_HIGH_MID_LOW    = 12'd2345;
	localparam logic [CFG_W-1:0] RST_HIGH_MID_HIGH   = 12'd2359;
	localparam logic [CFG_W-1:0] RST_FLAT_LOW        = 12'd2576;
	localparam logic [CFG_W-1:0] RST_FLAT_HIGH       = 12'd2592;

	// part type codes
	localparam logic [TYPE_W-1:0] PT_UNDEF = 2'd0;
	localparam logic [TYPE_W-1:0] PT_HOLE  = 2'd1;
	localparam logic [TYPE_W-1:0] PT_HIGH  = 2'd2;
	localparam logic [TYPE_W-1:0] PT_FLAT  = 2'd3;

	// profile status codes
	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_SHORT    = 2'd1;
	localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd2;

	// sequencer states
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_SUM,
		ST_CLASS,
		ST_DONE
	} state_t;

	// what the shared divider is working on
	typedef enum logic [2:0] {
		PH_N3,
		PH_OUTER,
		PH_MID,
		PH_H1,
		PH_H2
	} phase_t;

	// open band test, bounds excluded
	function automatic logic in_band(input logic [CMP_W-1:0] v,
		input logic [CMP_W-1:0] lo, input logic [CMP_W-1:0] hi);
		return (v > lo) && (v < hi);
	endfunction

	// (3640 - level) * 3, zero when the level reaches the zero line
	function automatic logic [NUM_W-1:0] height_num(input logic [16:0] level);
		logic [NUM_W-1:0] d;
		d = NUM_W'(ZERO_LEVEL) - NUM_W'(level);
		if (level >= 17'(ZERO_LEVEL)) begin
			return '0;
		end
		return NUM_W'({d, 1'b0}) + d;
	endfunction

endpackage

// ===== sv/hpc_ram.sv =====
// hpc_ram: generic single write port, single read port ram with registered read
// no dependencies; used by height_profile_classifier as the sample store

module hpc_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== sv/hpc_div.sv =====
// hpc_div: restoring divider, one quotient bit per cycle
// no dependencies; shared by every division of height_profile_classifier

module hpc_div #(
	parameter int DW = 22,
	parameter int VW = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int CW = $clog2(DW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] quo_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;

	logic [VW:0] trial;
	logic [VW:0] diff;
	logic        fits;

	// trial subtraction of one step
	always_comb begin
		trial = {rem_q, quo_q[DW-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = trial >= {1'b0, dvs_q};
	end

	// step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[VW-1:0] : trial[VW-1:0];
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== sv/height_profile_classifier.sv =====
// Height profile classifier. Samples of one workpiece stream in on the s_ side, one request per
// cycle, and are written to an on-chip sample store; the request with tlast closes the profile
// and yields one result on the m_ side (part type, two heights, status). Samples beyond
// MAX_SAMPLES are dropped and flagged. While a profile is evaluated the input is not ready:
// a sequencer drives one restoring divider (DW = clog2(MAX_SAMPLES+1) + SAMPLE_BITS steps per
// division) up to five times (N/3, outer average, middle average, two heights) and sums the
// outer and middle samples through the store's read port, one sample a cycle, with the store's
// registered read in between. An undefined part skips the two height divisions, and a profile
// shorter than 21 samples skips the divisions and sums altogether. A result waiting on m_ does
// not block loading of the next profile, but the evaluation of the next closing request holds
// in its done state until that result has been taken.
// depends on hpc_pkg, hpc_ram, hpc_div

module height_profile_classifier
	import hpc_pkg::*;
#(
	parameter int MAX_SAMPLES = 1024,
	parameter int SAMPLE_BITS = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	// input samples
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [15:0]      s_tdata,   // [11:0] sample
	input  logic             s_tlast,   // last_sample
	// results
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [31:0]      m_tdata,   // [1:0] part_type, [12:2] outer_height,
	                                    // [23:13] mean_height, [25:24] profile_status
	// configuration
	input  logic             cfg_we,
	input  logic [2:0]       cfg_addr,
	input  logic [CFG_W-1:0] cfg_wdata
);

	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int AW    = $clog2(MAX_SAMPLES);
	localparam int DW    = CNT_W + SAMPLE_BITS;

	state_t state_q, state_d;
	phase_t phase_q;

	logic [CFG_W-1:0] outer_high_low_q, outer_high_high_q;
	logic [CFG_W-1:0] hole_mid_low_q, hole_mid_high_q;
	logic [CFG_W-1:0] high_mid_low_q, high_mid_high_q;
	logic [CFG_W-1:0] flat_low_q, flat_high_q;

	logic [CNT_W-1:0]       count_q;
	logic                   ovf_q;
	logic [CNT_W-1:0]       n_q;
	logic [CNT_W-1:0]       outer_cnt_q;
	logic [AW-1:0]          rd_addr_q;
	logic [CNT_W-1:0]       rd_left_q;
	logic                   rd_pend_q;
	logic [DW-1:0]          acc_q;
	logic [SAMPLE_BITS-1:0] outer_q, middle_q;
	logic [TYPE_W-1:0]      ptype_q;
	logic [HEIGHT_W-1:0]    h1_q, h2_q;
	logic [STAT_W-1:0]      status_q;
	logic                   m_valid_q;
	logic [31:0]            m_data_q;

	logic                   accept;
	logic                   store_full;
	logic [CNT_W-1:0]       n_next;
	logic                   short_prof;
	logic                   wr_en;
	logic                   rd_en;
	logic [SAMPLE_BITS-1:0] rd_data;
	logic                   out_free;
	logic                   div_start;
	logic                   div_done;
	logic [DW-1:0]          div_q;
	logic [DW-1:0]          div_dividend;
	logic [CNT_W-1:0]       div_divisor;
	logic [CNT_W-1:0]       outer_cnt_d;
	logic [AW-1:0]          mid_start;
	logic [SAMPLE_BITS:0]   mean_sum;
	logic [TYPE_W-1:0]      class_type;
	logic [CMP_W-1:0]       outer_c, middle_c;

	// request bookkeeping
	always_comb begin
		accept     = s_tvalid & s_tready;
		store_full = count_q == CNT_W'(MAX_SAMPLES);
		n_next     = store_full ? count_q : count_q + CNT_W'(1);
		short_prof = n_next < CNT_W'(MIN_PROFILE);
		wr_en      = accept & ~store_full;
		rd_en      = (state_q == ST_SUM) && (rd_left_q != '0);
		div_start  = state_q == ST_DIV_START;
		out_free   = ~m_valid_q | m_tready;
		s_tready   = state_q == ST_LOAD;
	end

	// sample store
	hpc_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_SAMPLES)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (SAMPLE_BITS'(s_tdata[11:0])),
		.rd_en   (rd_en),
		.rd_addr (rd_addr_q),
		.rd_data (rd_data)
	);

	// operand select for the shared divider
	always_comb begin
		mean_sum = {1'b0, outer_q} + {1'b0, middle_q};
		case (phase_q)
			PH_N3: begin
				div_dividend = DW'(n_q);
				div_divisor  = CNT_W'(DIV_THIRD);
			end
			PH_OUTER: begin
				div_dividend = acc_q;
				div_divisor  = outer_cnt_q;
			end
			PH_MID: begin
				div_dividend = acc_q;
				div_divisor  = CNT_W'(DIV_TEN);
			end
			PH_H1: begin
				div_dividend = DW'(height_num(17'(outer_q)));
				div_divisor  = CNT_W'(DIV_TEN);
			end
			PH_H2: begin
				div_dividend = DW'(height_num(17'(mean_sum[SAMPLE_BITS:1])));
				div_divisor  = CNT_W'(DIV_TEN);
			end
			default: begin
				div_dividend = '0;
				div_divisor  = CNT_W'(DIV_TEN);
			end
		endcase
	end

	hpc_div #(
		.DW (DW),
		.VW (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_q)
	);

	// derived sum ranges
	always_comb begin
		outer_cnt_d = CNT_W'(div_q) - CNT_W'(OUTER_SKIP);
		mid_start   = AW'((n_q >> 1) - CNT_W'(MID_HALF));
	end

	// band classification of the two averages
	always_comb begin
		outer_c  = CMP_W'(outer_q);
		middle_c = CMP_W'(middle_q);
		class_type = PT_UNDEF;
		if (in_band(outer_c, CMP_W'(outer_high_low_q), CMP_W'(outer_high_high_q))) begin
			if (in_band(middle_c, CMP_W'(hole_mid_low_q), CMP_W'(hole_mid_high_q))) begin
				class_type = PT_HOLE;
			end else if (in_band(middle_c, CMP_W'(high_mid_low_q),
					CMP_W'(high_mid_high_q))) begin
				class_type = PT_HIGH;
			end
		end else if (in_band(outer_c, CMP_W'(flat_low_q), CMP_W'(flat_high_q)) &&
				in_band(middle_c, CMP_W'(flat_low_q), CMP_W'(flat_high_q))) begin
			class_type = PT_FLAT;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (accept && s_tlast) begin
					state_d = short_prof ? ST_DONE : ST_DIV_START;
				end
			end
			ST_DIV_START: begin
				state_d = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_done) begin
					unique case (phase_q)
						PH_N3, PH_OUTER: state_d = ST_SUM;
						PH_MID:          state_d = ST_CLASS;
						PH_H1:           state_d = ST_DIV_START;
						default:         state_d = ST_DONE;
					endcase
				end
			end
			ST_SUM: begin
				if ((rd_left_q == '0) && !rd_pend_q) begin
					state_d = ST_DIV_START;
				end
			end
			ST_CLASS: begin
				state_d = (class_type == PT_UNDEF) ? ST_DONE : ST_DIV_START;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outer_high_low_q  <= RST_OUTER_HIGH_LOW;
			outer_high_high_q <= RST_OUTER_HIGH_HIGH;
			hole_mid_low_q    <= RST_HOLE_MID_LOW;
			hole_mid_high_q   <= RST_HOLE_MID_HIGH;
			high_mid_low_q    <= RST_HIGH_MID_LOW;
			high_mid_high_q   <= RST_HIGH_MID_HIGH;
			flat_low_q        <= RST_FLAT_LOW;
			flat_high_q       <= RST_FLAT_HIGH;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_OUTER_HIGH_LOW:  outer_high_low_q  <= cfg_wdata;
				REG_OUTER_HIGH_HIGH: outer_high_high_q <= cfg_wdata;
				REG_HOLE_MID_LOW:    hole_mid_low_q    <= cfg_wdata;
				REG_HOLE_MID_HIGH:   hole_mid_high_q   <= cfg_wdata;
				REG_HIGH_MID_LOW:    high_mid_low_q    <= cfg_wdata;
				REG_HIGH_MID_HIGH:   high_mid_high_q   <= cfg_wdata;
				REG_FLAT_LOW:        flat_low_q        <= cfg_wdata;
				REG_FLAT_HIGH:       flat_high_q       <= cfg_wdata;
				default:             flat_high_q       <= flat_high_q;
			endcase
		end
	end

	// sample count, overflow flag, phase and read pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			ovf_q     <= 1'b0;
			phase_q   <= PH_N3;
			rd_pend_q <= 1'b0;
		end else begin
			rd_pend_q <= rd_en;
			if (accept) begin
				if (s_tlast) begin
					count_q <= '0;
					ovf_q   <= 1'b0;
					phase_q <= PH_N3;
				end else if (store_full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= n_next;
				end
			end
			if ((state_q == ST_DIV_WAIT) && div_done) begin
				unique case (phase_q)
					PH_N3:    phase_q <= PH_OUTER;
					PH_OUTER: phase_q <= PH_MID;
					PH_MID:   phase_q <= PH_H1;
					default:  phase_q <= PH_H2;
				endcase
			end
		end
	end

	// evaluation datapath
	always_ff @(posedge clk) begin
		if (accept && s_tlast) begin
			n_q <= n_next;
			if (short_prof) begin
				status_q <= STAT_SHORT;
				ptype_q  <= PT_UNDEF;
				h1_q     <= '0;
				h2_q     <= '0;
			end else begin
				status_q <= (ovf_q || store_full) ? STAT_OVERFLOW : STAT_OK;
			end
		end
		// capture the divider result
		if ((state_q == ST_DIV_WAIT) && div_done) begin
			case (phase_q)
				PH_N3: begin
					outer_cnt_q <= outer_cnt_d;
					rd_addr_q   <= AW'(1);
					rd_left_q   <= outer_cnt_d;
					acc_q       <= '0;
				end
				PH_OUTER: begin
					outer_q   <= SAMPLE_BITS'(div_q);
					rd_addr_q <= mid_start;
					rd_left_q <= CNT_W'(MID_LEN);
					acc_q     <= '0;
				end
				PH_MID: middle_q <= SAMPLE_BITS'(div_q);
				PH_H1:  h1_q     <= HEIGHT_W'(div_q);
				default: h2_q    <= HEIGHT_W'(div_q);
			endcase
		end
		// walk the stored samples
		if (state_q == ST_SUM) begin
			if (rd_en) begin
				rd_addr_q <= rd_addr_q + AW'(1);
				rd_left_q <= rd_left_q - CNT_W'(1);
			end
			if (rd_pend_q) begin
				acc_q <= acc_q + DW'(rd_data);
			end
		end
		if (state_q == ST_CLASS) begin
			ptype_q <= class_type;
			if (class_type == PT_UNDEF) begin
				h1_q <= '0;
				h2_q <= '0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			m_data_q <= {6'd0, status_q, h2_q, h1_q, ptype_q};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

// ===== tb/sv/hpc_checker.sv =====
`timescale 1ns / 100ps
// hpc_checker: watches the sample, result and configuration ports of height_profile_classifier,
// works out the verdict of every closed profile and compares it with the result that comes out
// depends on hpc_pkg

module hpc_checker
	import hpc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [15:0]      s_tdata,   // [11:0] sample
	input  logic             s_tlast,   // last_sample
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [31:0]      m_tdata,   // [1:0] part_type, [12:2] outer_height,
	                                    // [23:13] mean_height, [25:24] profile_status
	input  logic             cfg_we,
	input  logic [2:0]       cfg_addr,
	input  logic [CFG_W-1:0] cfg_wdata,
	output int               bad_verdicts,
	output int               verdicts_owed
);

	localparam int STORE_DEPTH = 1024;

	typedef struct packed {
		logic [TYPE_W-1:0]   part_type;
		logic [HEIGHT_W-1:0] outer_height;
		logic [HEIGHT_W-1:0] mean_height;
		logic [STAT_W-1:0]   profile_status;
	} verdict_t;

	logic [11:0]      sample_mem [STORE_DEPTH];
	int unsigned      stored;
	logic             store_overran;
	logic [CFG_W-1:0] outer_lo, outer_hi, hole_lo, hole_hi;
	logic [CFG_W-1:0] high_lo, high_hi, flat_lo, flat_hi;
	verdict_t         profile_verdicts [$];

	// open band, both bounds excluded
	function automatic logic band_hit(input int unsigned v, input logic [CFG_W-1:0] lo,
		input logic [CFG_W-1:0] hi);
		return (v > lo) && (v < hi);
	endfunction

	// height above the zero line, clamped at zero
	function automatic logic [HEIGHT_W-1:0] height_from(input int unsigned level);
		if (level >= ZERO_LEVEL) begin
			return '0;
		end
		return HEIGHT_W'(((ZERO_LEVEL - level) * 3) / DIV_TEN);
	endfunction

	// verdict of the profile held in the sample store
	function automatic verdict_t classify_profile();
		verdict_t        v;
		int unsigned     span, mid_from, outer_avg, mid_avg, k;
		longint unsigned acc;
		v = '0;
		if (stored < MIN_PROFILE) begin
			v.profile_status = STAT_SHORT;
			return v;
		end
		span = stored / DIV_THIRD - OUTER_SKIP;
		acc = 0;
		for (k = 1; k <= span; k++) begin
			acc += sample_mem[k];
		end
		outer_avg = acc / span;
		mid_from = stored / 2 - MID_HALF;
		acc = 0;
		for (k = 0; k < MID_LEN; k++) begin
			acc += sample_mem[mid_from + k];
		end
		mid_avg = acc / MID_LEN;
		v.part_type = PT_UNDEF;
		if (band_hit(outer_avg, outer_lo, outer_hi)) begin
			if (band_hit(mid_avg, hole_lo, hole_hi)) begin
				v.part_type = PT_HOLE;
			end else if (band_hit(mid_avg, high_lo, high_hi)) begin
				v.part_type = PT_HIGH;
			end
		end else if (band_hit(outer_avg, flat_lo, flat_hi) && band_hit(mid_avg, flat_lo, flat_hi)) begin
			v.part_type = PT_FLAT;
		end
		if (v.part_type != PT_UNDEF) begin
			v.outer_height = height_from(outer_avg);
			v.mean_height  = height_from((outer_avg + mid_avg) / 2);
		end
		v.profile_status = store_overran ? STAT_OVERFLOW : STAT_OK;
		return v;
	endfunction

	// compare one result request with the oldest verdict
	task automatic check_verdict();
		verdict_t want, got;
		got.part_type      = m_tdata[1:0];
		got.outer_height   = m_tdata[12:2];
		got.mean_height    = m_tdata[23:13];
		got.profile_status = m_tdata[25:24];
		if (profile_verdicts.size() == 0) begin
			$error("result with no closed profile waiting, m_tdata %h", m_tdata);
			bad_verdicts++;
			return;
		end
		want = profile_verdicts.pop_front();
		if (got.part_type !== want.part_type) begin
			$error("part_type expected %0d got %0d", want.part_type, got.part_type);
			bad_verdicts++;
		end
		if (got.outer_height !== want.outer_height) begin
			$error("outer_height expected %0d got %0d", want.outer_height, got.outer_height);
			bad_verdicts++;
		end
		if (got.mean_height !== want.mean_height) begin
			$error("mean_height expected %0d got %0d", want.mean_height, got.mean_height);
			bad_verdicts++;
		end
		if (got.profile_status !== want.profile_status) begin
			$error("profile_status expected %0d got %0d", want.profile_status,
				got.profile_status);
			bad_verdicts++;
		end
	endtask

	// track configuration, samples and results at every edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored        = 0;
			store_overran = 1'b0;
			outer_lo      = RST_OUTER_HIGH_LOW;
			outer_hi      = RST_OUTER_HIGH_HIGH;
			hole_lo       = RST_HOLE_MID_LOW;
			hole_hi       = RST_HOLE_MID_HIGH;
			high_lo       = RST_HIGH_MID_LOW;
			high_hi       = RST_HIGH_MID_HIGH;
			flat_lo       = RST_FLAT_LOW;
			flat_hi       = RST_FLAT_HIGH;
			profile_verdicts.delete();
			bad_verdicts  = 0;
			verdicts_owed = 0;
		end else begin
			// results first, so a verdict queued at this edge is not taken by it
			if (m_tvalid && m_tready) begin
				check_verdict();
			end
			if (cfg_we) begin
				case (reg_idx_t'(cfg_addr))
					REG_OUTER_HIGH_LOW:  outer_lo = cfg_wdata;
					REG_OUTER_HIGH_HIGH: outer_hi = cfg_wdata;
					REG_HOLE_MID_LOW:    hole_lo  = cfg_wdata;
					REG_HOLE_MID_HIGH:   hole_hi  = cfg_wdata;
					REG_HIGH_MID_LOW:    high_lo  = cfg_wdata;
					REG_HIGH_MID_HIGH:   high_hi  = cfg_wdata;
					REG_FLAT_LOW:        flat_lo  = cfg_wdata;
					REG_FLAT_HIGH:       flat_hi  = cfg_wdata;
				endcase
			end
			if (s_tvalid && s_tready) begin
				if (stored < STORE_DEPTH) begin
					sample_mem[stored] = s_tdata[11:0];
					stored++;
				end else begin
					store_overran = 1'b1;
				end
				if (s_tlast) begin
					profile_verdicts.push_back(classify_profile());
					stored        = 0;
					store_overran = 1'b0;
				end
			end
			verdicts_owed = profile_verdicts.size();
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: drives sample profiles and band settings into height_profile_classifier,
// stalls the result side at random and reports the verdict of hpc_checker
// depends on hpc_pkg, hpc_checker and the classifier RTL

module tb_top
	import hpc_pkg::*;
();

	localparam int STORE_DEPTH    = 1024;
	localparam int MAX_GAP        = 12;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES    = 1500;
	localparam int SETTLE_CYCLES  = 600;
	localparam int IDLE_GAP       = 16;
	localparam int PHASE_SAMPLES  = 10;
	localparam int HOLD_PROFILES  = 8;
	localparam int TOP_LEVEL      = 4095;

	typedef logic [CFG_W-1:0] band_set_t [8];

	logic             clk;
	logic             arst_n;
	logic             s_tvalid, s_tready, s_tlast;
	logic [15:0]      s_tdata;
	logic             m_tvalid, m_tready;
	logic [31:0]      m_tdata;
	logic             cfg_we;
	logic [2:0]       cfg_addr;
	logic [CFG_W-1:0] cfg_wdata;
	int               bad_verdicts, verdicts_owed;

	band_set_t   band_cfg;
	logic [11:0] profile_q [$];
	int          samples_sent;
	logic        tx_burst;
	logic        hold_results;
	int          quiet_cycles = 0;

	height_profile_classifier u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	hpc_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tlast       (s_tlast),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.bad_verdicts  (bad_verdicts),
		.verdicts_owed (verdicts_owed)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog on cycles with no request moving
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// result side: random stalls, bursts of readiness, one long hold on request
	initial begin : result_sink
		int gap, burst_left, hold_left;
		m_tready   = 1'b0;
		burst_left = 0;
		@(posedge arst_n);
		forever begin
			if (hold_results) begin
				m_tready = 1'b0;
				for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--) begin
					@(negedge clk);
				end
				hold_results = 1'b0;
			end
			if (burst_left > 0) begin
				gap = 0;
				burst_left--;
			end else begin
				gap = $urandom_range(0, MAX_GAP);
				if ($urandom_range(0, 15) == 0) begin
					burst_left = $urandom_range(10, 40);
				end
			end
			if (gap > 0) begin
				m_tready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready = 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			@(negedge clk);
		end
	end

	// level near v, one step either way when jittered
	function automatic logic [11:0] level_near(input int v, input bit jitter);
		int r;
		r = jitter ? v + $urandom_range(0, 2) - 1 : v;
		if (r < 0) begin
			return '0;
		end
		return (r > TOP_LEVEL) ? 12'(TOP_LEVEL) : 12'(r);
	endfunction

	// random point strictly inside a band, or its lower bound if the band is empty
	function automatic int band_pick(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
		return (hi > lo + 1) ? $urandom_range(lo + 1, hi - 1) : lo;
	endfunction

	function automatic int pick_outer();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4) begin
			return band_pick(band_cfg[REG_OUTER_HIGH_LOW], band_cfg[REG_OUTER_HIGH_HIGH]);
		end else if (r < 6) begin
			return band_pick(band_cfg[REG_FLAT_LOW], band_cfg[REG_FLAT_HIGH]);
		end else if (r == 6) begin
			return $urandom_range(0, 1) ? band_cfg[REG_OUTER_HIGH_LOW] :
				band_cfg[REG_OUTER_HIGH_HIGH];
		end else if (r == 7) begin
			return $urandom_range(0, 1) ? band_cfg[REG_FLAT_LOW] : band_cfg[REG_FLAT_HIGH];
		end
		return $urandom_range(0, TOP_LEVEL);
	endfunction

	function automatic int pick_mid();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3) begin
			return band_pick(band_cfg[REG_HOLE_MID_LOW], band_cfg[REG_HOLE_MID_HIGH]);
		end else if (r < 5) begin
			return band_pick(band_cfg[REG_HIGH_MID_LOW], band_cfg[REG_HIGH_MID_HIGH]);
		end else if (r < 7) begin
			return band_pick(band_cfg[REG_FLAT_LOW], band_cfg[REG_FLAT_HIGH]);
		end else if (r == 7) begin
			return band_cfg[reg_idx_t'($urandom_range(2, 7))];
		end
		return $urandom_range(0, TOP_LEVEL);
	endfunction

	// one profile of n samples with the outer and middle windows set to given levels
	task automatic build_profile(input int n, input int outer_t, input int mid_t,
		input bit jitter);
		int kept, span, mid_from, k;
		kept     = (n < STORE_DEPTH) ? n : STORE_DEPTH;
		span     = kept / DIV_THIRD - OUTER_SKIP;
		mid_from = kept / 2 - MID_HALF;
		profile_q.delete();
		for (k = 0; k < n; k++) begin
			if (kept >= MIN_PROFILE && k >= 1 && k <= span) begin
				profile_q.push_back(level_near(outer_t, jitter));
			end else if (kept >= MIN_PROFILE && k >= mid_from && k < mid_from + MID_LEN) begin
				profile_q.push_back(level_near(mid_t, jitter));
			end else begin
				profile_q.push_back(12'($urandom_range(0, TOP_LEVEL)));
			end
		end
	endtask

	task automatic uniform_profile(input int n, input logic [11:0] v);
		int k;
		profile_q.delete();
		for (k = 0; k < n; k++) begin
			profile_q.push_back(v);
		end
	endtask

	// one sample request; valid stays up afterwards until the next call or a drain
	task automatic send_sample(input logic [11:0] value, input logic last);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  = {4'b0, value};
		s_tlast  = last;
		s_tvalid = 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		samples_sent++;
	endtask

	task automatic send_profile();
		int k;
		for (k = 0; k < profile_q.size(); k++) begin
			send_sample(profile_q[k], k == profile_q.size() - 1);
		end
	endtask

	task automatic run_profile(input int n, input int outer_t, input int mid_t,
		input bit jitter);
		build_profile(n, outer_t, mid_t, jitter);
		send_profile();
	endtask

	task automatic random_profile();
		int n, r;
		r = $urandom_range(0, 19);
		if (r < 2) begin
			n = $urandom_range(1, MIN_PROFILE - 1);
		end else if (r < 4) begin
			n = $urandom_range(41, 96);
		end else begin
			n = $urandom_range(MIN_PROFILE, 40);
		end
		tx_burst = ($urandom_range(0, 3) == 0);
		run_profile(n, pick_outer(), pick_mid(), $urandom_range(0, 1));
	endtask

	// stop offering and wait until every verdict has come back
	task automatic drain_results();
		s_tvalid = 1'b0;
		s_tlast  = 1'b0;
		while (verdicts_owed != 0) @(negedge clk);
		repeat (IDLE_GAP) @(negedge clk);
	endtask

	// write all eight band registers, block idle
	task automatic program_bands(input band_set_t bs);
		reg_idx_t idx;
		idx = idx.first();
		do begin
			cfg_we    = 1'b1;
			cfg_addr  = idx;
			cfg_wdata = bs[idx];
			band_cfg[idx] = bs[idx];
			@(negedge clk);
			idx = idx.next();
		end while (idx != idx.first());
		cfg_we = 1'b0;
	endtask

	// main stimulus
	initial begin : stimulus
		band_set_t bs;
		int        goal, k, lo;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tlast      = 1'b0;
		cfg_we       = 1'b0;
		cfg_addr     = REG_OUTER_HIGH_LOW;
		cfg_wdata    = '0;
		tx_burst     = 1'b0;
		hold_results = 1'b0;
		samples_sent = 0;
		band_cfg = '{RST_OUTER_HIGH_LOW, RST_OUTER_HIGH_HIGH, RST_HOLE_MID_LOW,
			RST_HOLE_MID_HIGH, RST_HIGH_MID_LOW, RST_HIGH_MID_HIGH, RST_FLAT_LOW,
			RST_FLAT_HIGH};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed profiles under the reset bands
		uniform_profile(1, 12'hfff);            // single sample, too short
		send_profile();
		uniform_profile(MIN_PROFILE - 1, '0);   // one short of the minimum
		send_profile();
		run_profile(MIN_PROFILE, 2370, 3200, 0); // hole at minimum length
		run_profile(24, 2370, 2350, 0);          // high part
		run_profile(27, 2584, 2584, 0);          // flat part
		run_profile(22, 2345, 3200, 0);          // outer on lower bound
		run_profile(22, 2400, 3200, 0);          // outer on upper bound
		run_profile(25, 2370, 3000, 0);          // middle on hole bound
		run_profile(25, 2370, 2500, 0);          // middle in no band
		run_profile(28, 2584, 2592, 0);          // flat middle on upper bound
		uniform_profile(21, 12'hfff);
		send_profile();
		uniform_profile(21, '0);
		send_profile();
		run_profile(23, 2371, 3201, 1);          // truncated averages
		run_profile(STORE_DEPTH + 2, 2370, 3200, 0); // store fills, then overflows
		drain_results();

		// band settings: widest, all zero, all top, random, reset values
		for (k = 0; k < 5; k++) begin
			case (k)
				0: bs = '{0, TOP_LEVEL, 0, TOP_LEVEL, 0, TOP_LEVEL, 0, TOP_LEVEL};
				1: bs = '{default: '0};
				2: bs = '{default: 12'(TOP_LEVEL)};
				3: begin
					for (lo = 0; lo < 8; lo += 2) begin
						bs[lo]     = 12'($urandom_range(0, TOP_LEVEL));
						bs[lo + 1] = (bs[lo] + $urandom_range(0, 300) > TOP_LEVEL) ?
							12'(TOP_LEVEL) : 12'(bs[lo] + $urandom_range(0, 300));
					end
				end
				default: bs = '{RST_OUTER_HIGH_LOW, RST_OUTER_HIGH_HIGH, RST_HOLE_MID_LOW,
					RST_HOLE_MID_HIGH, RST_HIGH_MID_LOW, RST_HIGH_MID_HIGH, RST_FLAT_LOW,
					RST_FLAT_HIGH};
			endcase
			program_bands(bs);
			if (k == 0) begin
				// heights clamp at zero above the zero line
				tx_burst = 1'b0;
				run_profile(30, 3700, 4000, 0);
				run_profile(30, 4094, 4094, 0);
			end
			goal = samples_sent + PHASE_SAMPLES;
			while (samples_sent < goal) begin
				random_profile();
			end
			drain_results();
		end

		// long result hold while short profiles keep coming, input must back up
		hold_results = 1'b1;
		tx_burst     = 1'b1;
		for (k = 0; k < HOLD_PROFILES; k++) begin
			build_profile($urandom_range(1, 4), 0, 0, 0);
			send_profile();
		end
		drain_results();

		repeat (SETTLE_CYCLES) @(negedge clk);
		if (bad_verdicts == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
